/* hw/rtl/csv_record_field_splitter_core_defines.svh */
// ----------------------------------------------------------------------------
// CSV field splitter assertion macros
// Shared property forms for the checker of the splitter core.
// ----------------------------------------------------------------------------
`ifndef CSV_RECORD_FIELD_SPLITTER_CORE_DEFINES_SVH
`define CSV_RECORD_FIELD_SPLITTER_CORE_DEFINES_SVH

// Overlapping implication: the consequent holds in the same cycle.
`define CSVFS_ASSERT_SAME(label, clk, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error(msg);

// Non-overlapping implication: the consequent holds in the next cycle.
`define CSVFS_ASSERT_NEXT(label, clk, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/csvfs_pkg.sv */
// ----------------------------------------------------------------------------
// CSV field splitter package
// Shared constants, character codes and the command passed front to back.
// ----------------------------------------------------------------------------
package csvfs_pkg;

  // Field counting
  localparam int FIELD_COUNT = 11;
  localparam int FC_W        = $clog2(FIELD_COUNT + 1);
  localparam int FIDX_W      = 4;
  localparam int MASK_BITS   = 11;
  localparam int MASK_IDX_W  = $clog2(MASK_BITS);
  localparam logic [MASK_BITS-1:0] LIST_MASK_RESET = 11'd1048;

  // Space run counter
  localparam int SP_W = 12;
  localparam logic [SP_W-1:0] SPACE_MAX = 12'd4095;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_UPN   = 8'h4E;
  localparam logic [7:0] CH_LOWA  = 8'h61;

  // Result kinds
  localparam logic [1:0] KIND_CHAR  = 2'd0;
  localparam logic [1:0] KIND_ELEM  = 2'd1;
  localparam logic [1:0] KIND_FIELD = 2'd2;

  // Emit slots of one command, sent lowest bit first
  localparam int EMIT_CHAR      = 0;
  localparam int EMIT_ELEM_PRE  = 1;
  localparam int EMIT_NAN_N0    = 2;
  localparam int EMIT_NAN_A     = 3;
  localparam int EMIT_NAN_N1    = 4;
  localparam int EMIT_ELEM_POST = 5;
  localparam int EMIT_FIELD     = 6;
  localparam int EMIT_W         = 7;

  // Command queue
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Configuration port
  localparam int PADDR_W = 3;
  localparam logic [PADDR_W-3:0] REG_LIST_MASK = 1'b0;

  typedef struct packed {
    logic [EMIT_W-1:0] emit;
    logic [7:0]        ch;
    logic [SP_W-1:0]   sp;
    logic [FIDX_W-1:0] fidx;
    logic              rec;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

/* hw/rtl/csvfs_fifo.sv */
// ----------------------------------------------------------------------------
// CSV field splitter command queue
// Short register queue that decouples the byte classifier from the emitter.
// ----------------------------------------------------------------------------
module csvfs_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  csvfs_pkg::cmd_t      wr_data,
  input  logic                 pop,
  output csvfs_pkg::cmd_t      rd_data,
  output csvfs_pkg::fifo_stat_t stat
);

  csvfs_pkg::cmd_t                         mem [csvfs_pkg::FIFO_DEPTH];
  logic [csvfs_pkg::FIFO_PTR_W-1:0]        wr_ptr;
  logic [csvfs_pkg::FIFO_PTR_W-1:0]        rd_ptr;
  logic [csvfs_pkg::FIFO_CNT_W-1:0]        count;
  logic                                    do_push;
  logic                                    do_pop;

  assign stat.full  = (count == csvfs_pkg::FIFO_CNT_W'(csvfs_pkg::FIFO_DEPTH));
  assign stat.empty = (count == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rd_data    = mem[rd_ptr];

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == csvfs_pkg::FIFO_PTR_W'(csvfs_pkg::FIFO_DEPTH - 1)) ?
                  '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == csvfs_pkg::FIFO_PTR_W'(csvfs_pkg::FIFO_DEPTH - 1)) ?
                  '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* hw/rtl/csvfs_front.sv */
// ----------------------------------------------------------------------------
// CSV field splitter front end
// Tracks quoting, spaces and field position per byte and issues commands.
// ----------------------------------------------------------------------------
module csvfs_front (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [7:0]                            in_byte,
  input  logic [csvfs_pkg::MASK_BITS-1:0]       list_mask,
  input  csvfs_pkg::fifo_stat_t                 stat,
  output logic                                  cmd_push,
  output csvfs_pkg::cmd_t                       cmd
);

  localparam int FcW     = csvfs_pkg::FC_W;
  localparam int FidxW   = csvfs_pkg::FIDX_W;
  localparam int MaskIdxW = csvfs_pkg::MASK_IDX_W;

  logic                        inside_quotes, inside_quotes_next;
  logic                        quote_pending, quote_pending_next;
  logic [FcW-1:0]              field_counter, field_counter_next;
  logic                        element_started, element_started_next;
  logic [csvfs_pkg::SP_W-1:0]  held_space_count, held_space_count_next;
  logic                        field_has_element, field_has_element_next;

  logic accept;
  logic live;
  logic is_list;
  logic quotes_eff;
  logic do_char;
  logic do_close;
  logic close_rec;
  logic [7:0] char_val;

  assign in_ready   = !stat.full;
  assign accept     = in_valid && in_ready;
  assign live       = (field_counter < FcW'(csvfs_pkg::FIELD_COUNT));
  assign is_list    = (field_counter < FcW'(csvfs_pkg::MASK_BITS)) &&
                      list_mask[MaskIdxW'(field_counter)];
  assign quotes_eff = quote_pending ? 1'b0 : inside_quotes;
  assign cmd_push   = accept && (cmd.emit != '0);

  // Classify the byte
  always_comb begin
    do_char   = 1'b0;
    do_close  = 1'b0;
    close_rec = 1'b0;
    char_val  = in_byte;
    inside_quotes_next = inside_quotes;
    quote_pending_next = quote_pending;
    if (accept) begin
      quote_pending_next = 1'b0;
      if (quote_pending && in_byte == csvfs_pkg::CH_QUOTE) begin
        // doubled quote inside quotes: literal quote
        do_char = 1'b1;
      end else begin
        inside_quotes_next = quotes_eff;
        if (in_byte == csvfs_pkg::CH_NUL || in_byte == csvfs_pkg::CH_NL) begin
          do_close  = 1'b1;
          close_rec = 1'b1;
        end else if (in_byte == csvfs_pkg::CH_QUOTE) begin
          if (quotes_eff) begin
            quote_pending_next = 1'b1;
          end else begin
            inside_quotes_next = 1'b1;
          end
        end else if (in_byte == csvfs_pkg::CH_COMMA) begin
          if (!quotes_eff) begin
            do_close = 1'b1;
          end else if (!is_list) begin
            do_char = 1'b1;
          end
        end else if (in_byte != csvfs_pkg::CH_SPACE) begin
          do_char = 1'b1;
        end
      end
    end
  end

  // Build the command and the next value state
  always_comb begin
    cmd.emit = '0;
    cmd.ch   = char_val;
    cmd.sp   = '0;
    cmd.fidx = FidxW'(field_counter);
    cmd.rec  = 1'b0;
    field_counter_next     = field_counter;
    element_started_next   = element_started;
    held_space_count_next  = held_space_count;
    field_has_element_next = field_has_element;

    if (accept) begin
      // interior space run and quoted list separator
      if (!do_char && !do_close) begin
        if (in_byte == csvfs_pkg::CH_SPACE && !quote_pending) begin
          if (element_started && held_space_count < csvfs_pkg::SPACE_MAX) begin
            held_space_count_next = held_space_count + 1'b1;
          end
        end else if (in_byte == csvfs_pkg::CH_SPACE && quote_pending) begin
          if (element_started && held_space_count < csvfs_pkg::SPACE_MAX) begin
            held_space_count_next = held_space_count + 1'b1;
          end
        end else if (in_byte == csvfs_pkg::CH_COMMA && quotes_eff && is_list) begin
          if (element_started) begin
            cmd.emit[csvfs_pkg::EMIT_ELEM_PRE] = live;
            element_started_next  = 1'b0;
            held_space_count_next = '0;
          end
        end
      end

      // value character
      if (do_char) begin
        cmd.emit[csvfs_pkg::EMIT_CHAR] = live;
        cmd.sp = element_started ? held_space_count : '0;
        element_started_next   = 1'b1;
        field_has_element_next = 1'b1;
        held_space_count_next  = '0;
      end

      // field close
      if (do_close) begin
        if (live) begin
          cmd.emit[csvfs_pkg::EMIT_ELEM_PRE] = is_list && element_started;
          if (!field_has_element) begin
            cmd.emit[csvfs_pkg::EMIT_NAN_N0]    = 1'b1;
            cmd.emit[csvfs_pkg::EMIT_NAN_A]     = 1'b1;
            cmd.emit[csvfs_pkg::EMIT_NAN_N1]    = 1'b1;
            cmd.emit[csvfs_pkg::EMIT_ELEM_POST] = is_list;
          end
          cmd.emit[csvfs_pkg::EMIT_FIELD] = 1'b1;
          cmd.rec = close_rec;
        end
        element_started_next   = 1'b0;
        held_space_count_next  = '0;
        field_has_element_next = 1'b0;
        if (close_rec) begin
          field_counter_next = '0;
        end else if (live) begin
          field_counter_next = field_counter + 1'b1;
        end
      end
    end
  end

  // Hold parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      inside_quotes     <= 1'b0;
      quote_pending     <= 1'b0;
      field_counter     <= '0;
      element_started   <= 1'b0;
      held_space_count  <= '0;
      field_has_element <= 1'b0;
    end else begin
      inside_quotes     <= (do_close && close_rec) ? 1'b0 : inside_quotes_next;
      quote_pending     <= (do_close && close_rec) ? 1'b0 : quote_pending_next;
      field_counter     <= field_counter_next;
      element_started   <= element_started_next;
      held_space_count  <= held_space_count_next;
      field_has_element <= field_has_element_next;
    end
  end

endmodule

/* hw/rtl/csvfs_back.sv */
// ----------------------------------------------------------------------------
// CSV field splitter back end
// Expands each queued command into its result beats, lowest slot first.
// ----------------------------------------------------------------------------
module csvfs_back (
  input  logic                  clk,
  input  logic                  rst,
  input  csvfs_pkg::cmd_t       fifo_data,
  input  csvfs_pkg::fifo_stat_t stat,
  output logic                  fifo_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_kind,
  output logic [7:0]            out_char,
  output logic [csvfs_pkg::SP_W-1:0]   out_sp,
  output logic [csvfs_pkg::FIDX_W-1:0] out_fidx,
  output logic                  out_rec,
  output logic                  out_last
);

  csvfs_pkg::cmd_t                  cur;
  logic                             cur_valid;
  logic [csvfs_pkg::EMIT_W-1:0]     rest;
  logic                             beat;
  logic                             last;

  assign rest      = cur.emit & (cur.emit - 1'b1);
  assign last      = (rest == '0);
  assign beat      = cur_valid && out_ready;
  assign fifo_pop  = !stat.empty && (!cur_valid || (beat && last));
  assign out_valid = cur_valid;
  assign out_fidx  = cur.fidx;
  assign out_last  = last;

  // Select the beat for the lowest pending slot
  always_comb begin
    out_kind = csvfs_pkg::KIND_FIELD;
    out_char = '0;
    out_sp   = '0;
    out_rec  = 1'b0;
    if (cur.emit[csvfs_pkg::EMIT_CHAR]) begin
      out_kind = csvfs_pkg::KIND_CHAR;
      out_char = cur.ch;
      out_sp   = cur.sp;
    end else if (cur.emit[csvfs_pkg::EMIT_ELEM_PRE]) begin
      out_kind = csvfs_pkg::KIND_ELEM;
    end else if (cur.emit[csvfs_pkg::EMIT_NAN_N0]) begin
      out_kind = csvfs_pkg::KIND_CHAR;
      out_char = csvfs_pkg::CH_UPN;
    end else if (cur.emit[csvfs_pkg::EMIT_NAN_A]) begin
      out_kind = csvfs_pkg::KIND_CHAR;
      out_char = csvfs_pkg::CH_LOWA;
    end else if (cur.emit[csvfs_pkg::EMIT_NAN_N1]) begin
      out_kind = csvfs_pkg::KIND_CHAR;
      out_char = csvfs_pkg::CH_UPN;
    end else if (cur.emit[csvfs_pkg::EMIT_ELEM_POST]) begin
      out_kind = csvfs_pkg::KIND_ELEM;
    end else begin
      out_rec = cur.rec;
    end
  end

  // Load the next command or drop the sent slot
  always_ff @(posedge clk) begin
    if (fifo_pop) begin
      cur <= fifo_data;
    end else if (beat) begin
      cur.emit <= rest;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
    end else if (fifo_pop) begin
      cur_valid <= 1'b1;
    end else if (beat && last) begin
      cur_valid <= 1'b0;
    end
  end

endmodule

/* hw/rtl/csv_record_field_splitter_core.sv */
// ----------------------------------------------------------------------------
// CSV record field splitter core
// Splits CSV text into field values, list elements and field ends.
// ----------------------------------------------------------------------------
// Input stream s_*: one text byte per beat in s_tdata[7:0]; a newline or NUL
// ends the record. Output stream m_*: one result per beat; m_tlast marks the
// final result of an input byte. A byte that only updates parser state (a
// quote, a space, a skipped separator) gives no output beat.
// The front end accepts a byte every cycle while its 4-entry command queue
// has room. The back end sends one beat per cycle while m_tready is high: a
// value character gives one beat, a field end up to five beats (element end,
// N, a, N, element end, field end), one per slot that the emitter must walk.
// An input byte passes through the command queue and the emitter's command register.
// A stalled receiver holds the output beat; the queue then fills and
// s_tready drops. Reset clears quoting, the field counter and the queue and
// sets list_field_mask to its default; there is no clearing pass.
// APB register 0 (address 0): list_field_mask[10:0]; the user must write it only
// while the block is idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module csv_record_field_splitter_core (
  input  logic                            clk,
  input  logic                            rst,
  // slave stream: [7:0] text_byte
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,
  // master stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [7:0] char_out, [19:8] spaces_before, [23:20] field_index
  output logic [23:0]                     m_tdata,
  // [1:0] item_kind, [2] record_end
  output logic [2:0]                      m_tuser,
  output logic                            m_tlast,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [csvfs_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  logic [csvfs_pkg::MASK_BITS-1:0]   list_field_mask;
  logic                              reg_hit;
  csvfs_pkg::cmd_t                   push_cmd;
  csvfs_pkg::cmd_t                   head_cmd;
  csvfs_pkg::fifo_stat_t             stat;
  logic                              cmd_push;
  logic                              cmd_pop;
  logic [1:0]                        out_kind;
  logic [7:0]                        out_char;
  logic [csvfs_pkg::SP_W-1:0]        out_sp;
  logic [csvfs_pkg::FIDX_W-1:0]      out_fidx;
  logic                              out_rec;

  // Register file
  assign pready  = 1'b1;
  assign reg_hit = (paddr[csvfs_pkg::PADDR_W-1:2] == csvfs_pkg::REG_LIST_MASK);
  assign prdata  = reg_hit ? {{(32 - csvfs_pkg::MASK_BITS){1'b0}}, list_field_mask} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      list_field_mask <= csvfs_pkg::LIST_MASK_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      list_field_mask <= pwdata[csvfs_pkg::MASK_BITS-1:0];
    end
  end

  csvfs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_byte   (s_tdata),
    .list_mask (list_field_mask),
    .stat      (stat),
    .cmd_push  (cmd_push),
    .cmd       (push_cmd)
  );

  csvfs_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (cmd_push),
    .wr_data (push_cmd),
    .pop     (cmd_pop),
    .rd_data (head_cmd),
    .stat    (stat)
  );

  csvfs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .fifo_data (head_cmd),
    .stat      (stat),
    .fifo_pop  (cmd_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_kind  (out_kind),
    .out_char  (out_char),
    .out_sp    (out_sp),
    .out_fidx  (out_fidx),
    .out_rec   (out_rec),
    .out_last  (m_tlast)
  );

  // Pack the result beat
  assign m_tdata = {out_fidx, out_sp, out_char};
  assign m_tuser = {out_rec, out_kind};

endmodule

/* hw/rtl/csvfs_checker.sv */
// ----------------------------------------------------------------------------
// CSV field splitter port checker
// Watches the top-level ports for result ordering and reset behavior.
// ----------------------------------------------------------------------------
`include "csv_record_field_splitter_core_defines.svh"

module csvfs_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [23:0]                   m_tdata,
  input logic [2:0]                    m_tuser,
  input logic                          m_tlast
);

  logic is_field_end;

  assign is_field_end = (m_tuser[1:0] == csvfs_pkg::KIND_FIELD);

  // Stalled beat holds
  `CSVFS_ASSERT_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "output beat changed while stalled")

  // Nothing is shown right after reset
  `CSVFS_ASSERT_NEXT(a_reset_idle, clk, 1'b0, rst, !m_tvalid, "output valid after reset")

  // A field end always closes the run of its byte
  `CSVFS_ASSERT_SAME(a_field_last, clk, rst, m_tvalid && is_field_end, m_tlast, "field end not last of run")

  // Record end only rides on a field end
  `CSVFS_ASSERT_SAME(a_rec_kind, clk, rst, m_tvalid && m_tuser[2], is_field_end, "record end on non-field item")

  // Dropped fields never reach the output
  `CSVFS_ASSERT_SAME(a_fidx_range, clk, rst, m_tvalid, m_tdata[23:20] < 4'(csvfs_pkg::FIELD_COUNT), "field index out of range")

endmodule

bind csv_record_field_splitter_core csvfs_checker u_csvfs_checker (.*);
